// ===== hw/rtl/q2r_pkg.sv =====
package q2r_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 14;

    // Width of one quaternion part and of one matrix element.
    localparam int PART_W = 16;
    localparam int ELEM_W = 16;

    // Width of a squared product and of the squared norm (at most 2^32).
    localparam int PROD_W = 32;
    localparam int DEN_W  = 33;

    // Signed width of an element numerator (magnitude up to 2^32).
    localparam int NUM_W = 34;

    // Number of matrix elements.
    localparam int NUM_LANES = 9;

    typedef logic [DEN_W-1:0] mag_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ===== hw/rtl/q2r_front.sv =====
module q2r_front (
    input  logic                                  clk,
    input  logic                                  en_prod,
    input  logic                                  en_num,
    input  logic signed [q2r_pkg::PART_W-1:0]     quat_w,
    input  logic signed [q2r_pkg::PART_W-1:0]     quat_x,
    input  logic signed [q2r_pkg::PART_W-1:0]     quat_y,
    input  logic signed [q2r_pkg::PART_W-1:0]     quat_z,
    output q2r_pkg::mag_t                         den,
    output q2r_pkg::mag_t                         mag [q2r_pkg::NUM_LANES],
    output logic [q2r_pkg::NUM_LANES-1:0]         neg,
    output logic                                  zero
);
    import q2r_pkg::*;

    prod_t p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    prod_t p_xy_reg, p_zw_reg, p_xz_reg, p_yw_reg, p_yz_reg, p_xw_reg;

    logic signed [NUM_W-1:0] num [NUM_LANES];
    logic signed [NUM_W-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
    logic signed [NUM_W-1:0] neg_num [NUM_LANES];
    mag_t den_next;
    mag_t den_reg;
    mag_t mag_reg [NUM_LANES];
    logic [NUM_LANES-1:0] neg_reg;
    logic zero_reg;

    // First stage: the ten products of the quaternion parts.
    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            p_ww_reg <= quat_w * quat_w;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_zw_reg <= quat_z * quat_w;
            p_xz_reg <= quat_x * quat_z;
            p_yw_reg <= quat_y * quat_w;
            p_yz_reg <= quat_y * quat_z;
            p_xw_reg <= quat_x * quat_w;
        end
    end

    // Second stage: numerators, their signs and magnitudes, and the norm.
    always_comb
    begin
        ww = NUM_W'(p_ww_reg);
        xx = NUM_W'(p_xx_reg);
        yy = NUM_W'(p_yy_reg);
        zz = NUM_W'(p_zz_reg);
        xy = NUM_W'(p_xy_reg);
        zw = NUM_W'(p_zw_reg);
        xz = NUM_W'(p_xz_reg);
        yw = NUM_W'(p_yw_reg);
        yz = NUM_W'(p_yz_reg);
        xw = NUM_W'(p_xw_reg);
        num[0] = xx - yy - zz + ww;
        num[1] = (xy - zw) <<< 1;
        num[2] = (xz + yw) <<< 1;
        num[3] = (xy + zw) <<< 1;
        num[4] = yy - xx - zz + ww;
        num[5] = (yz - xw) <<< 1;
        num[6] = (xz - yw) <<< 1;
        num[7] = (yz + xw) <<< 1;
        num[8] = zz - xx - yy + ww;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            neg_num[i] = -num[i];
        end
        den_next = DEN_W'(unsigned'(p_ww_reg)) + DEN_W'(unsigned'(p_xx_reg))
                 + DEN_W'(unsigned'(p_yy_reg)) + DEN_W'(unsigned'(p_zz_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en_num)
        begin
            den_reg  <= den_next;
            zero_reg <= (den_next == '0);
            for (int i = 0; i < NUM_LANES; i++)
            begin
                neg_reg[i] <= num[i][NUM_W-1];
                mag_reg[i] <= num[i][NUM_W-1] ? neg_num[i][DEN_W-1:0]
                                               : num[i][DEN_W-1:0];
            end
        end
    end

    assign den  = den_reg;
    assign mag  = mag_reg;
    assign neg  = neg_reg;
    assign zero = zero_reg;

endmodule

// ===== hw/rtl/q2r_div_stage.sv =====
module q2r_div_stage #(
    parameter int QW    = q2r_pkg::FRAC_BITS_DEF + 2,
    parameter bit SHIFT = 1'b1
) (
    input  logic                            clk,
    input  logic                            en,
    input  q2r_pkg::mag_t                   den_in,
    input  q2r_pkg::mag_t                   rem_in [q2r_pkg::NUM_LANES],
    input  logic [QW-1:0]                   q_in   [q2r_pkg::NUM_LANES],
    input  logic [q2r_pkg::NUM_LANES-1:0]   neg_in,
    input  logic                            zero_in,
    output q2r_pkg::mag_t                   den_out,
    output q2r_pkg::mag_t                   rem_out [q2r_pkg::NUM_LANES],
    output logic [QW-1:0]                   q_out   [q2r_pkg::NUM_LANES],
    output logic [q2r_pkg::NUM_LANES-1:0]   neg_out,
    output logic                            zero_out
);
    import q2r_pkg::*;

    logic [DEN_W:0] trial [NUM_LANES];
    logic [DEN_W:0] diff  [NUM_LANES];
    logic [NUM_LANES-1:0] qbit;

    mag_t den_reg;
    mag_t rem_reg [NUM_LANES];
    logic [QW-1:0] q_reg [NUM_LANES];
    logic [NUM_LANES-1:0] neg_reg;
    logic zero_reg;

    // One restoring division step for every lane.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            trial[i] = SHIFT ? {rem_in[i], 1'b0} : {1'b0, rem_in[i]};
            qbit[i]  = (trial[i] >= {1'b0, den_in});
            diff[i]  = trial[i] - {1'b0, den_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                rem_reg[i] <= qbit[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
                q_reg[i]   <= {q_in[i][QW-2:0], qbit[i]};
            end
        end
    end

    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign neg_out  = neg_reg;
    assign zero_out = zero_reg;

endmodule

// ===== hw/rtl/q2r_out.sv =====
module q2r_out #(
    parameter int FRAC_BITS = q2r_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [FRAC_BITS+1:0]                q_in [q2r_pkg::NUM_LANES],
    input  logic [q2r_pkg::NUM_LANES-1:0]       neg_in,
    input  logic                                zero_in,
    output logic signed [q2r_pkg::ELEM_W-1:0]   elem [q2r_pkg::NUM_LANES],
    output logic                                zero
);
    import q2r_pkg::*;

    localparam int QW    = FRAC_BITS + 2;
    localparam int EXT_W = 40;
    localparam logic signed [EXT_W-1:0] ONE     = EXT_W'(1) <<< FRAC_BITS;
    localparam logic signed [EXT_W-1:0] ELEM_MAX = EXT_W'((1 << (ELEM_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] ELEM_MIN = -(EXT_W'(1 << (ELEM_W - 1)));

    logic [QW:0] inc [NUM_LANES];
    logic signed [EXT_W-1:0] mag [NUM_LANES];
    logic signed [EXT_W-1:0] sval [NUM_LANES];
    logic signed [ELEM_W-1:0] elem_next [NUM_LANES];
    logic signed [ELEM_W-1:0] elem_reg [NUM_LANES];
    logic zero_reg;

    // Round half away from zero, clamp to one, apply sign, fit element width; a zero norm gives zero.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            inc[i] = {1'b0, q_in[i]} + (QW+1)'(1);
            mag[i] = EXT_W'(inc[i][QW:1]);
            if (mag[i] > ONE)
            begin
                mag[i] = ONE;
            end
            sval[i] = neg_in[i] ? -mag[i] : mag[i];
            if (zero_in)
            begin
                elem_next[i] = '0;
            end
            else if (sval[i] > ELEM_MAX)
            begin
                elem_next[i] = ELEM_MAX[ELEM_W-1:0];
            end
            else if (sval[i] < ELEM_MIN)
            begin
                elem_next[i] = ELEM_MIN[ELEM_W-1:0];
            end
            else
            begin
                elem_next[i] = sval[i][ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elem_reg <= elem_next;
            zero_reg <= zero_in;
        end
    end

    assign elem = elem_reg;
    assign zero = zero_reg;

endmodule

// ===== hw/rtl/quaternion_to_rotation_matrix_unit.sv =====
// Quaternion to 3x3 rotation matrix.
// Input channel: in_valid/in_ready with quat_w, quat_x, quat_y, quat_z in
// signed fixed point. Output channel: out_valid/out_ready with the nine
// elements rot_00..rot_22 in row-major order and the zero_norm flag.
// Every element is divided by the squared norm, rounded to nearest with ties
// away from zero and saturated to plus or minus one.
// The pipeline has a product stage, a numerator stage, FRAC_BITS + 2
// restoring division steps (one quotient bit per stage across nine lanes)
// and an output register. One item is accepted per cycle while in_ready is high.
// Reset clears all stage valid bits; the datapath registers are not reset.
// When the receiver stalls, the last stage holds its item and empty stages
// ahead of it keep filling, so in_ready drops only once every stage is full.
module quaternion_to_rotation_matrix_unit #(
    parameter int FRAC_BITS = q2r_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [q2r_pkg::PART_W-1:0]  quat_w,
    input  logic signed [q2r_pkg::PART_W-1:0]  quat_x,
    input  logic signed [q2r_pkg::PART_W-1:0]  quat_y,
    input  logic signed [q2r_pkg::PART_W-1:0]  quat_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_00,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_01,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_02,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_10,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_11,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_12,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_20,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_21,
    output logic signed [q2r_pkg::ELEM_W-1:0]  rot_22,
    output logic                               zero_norm
);
    import q2r_pkg::*;

    localparam int QW     = FRAC_BITS + 2;
    localparam int NSTEPS = FRAC_BITS + 2;
    localparam int NS     = NSTEPS + 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   rdy;

    mag_t den_s  [NSTEPS+1];
    mag_t rem_s  [NSTEPS+1][NUM_LANES];
    logic [QW-1:0] q_s [NSTEPS+1][NUM_LANES];
    logic [NUM_LANES-1:0] neg_s [NSTEPS+1];
    logic zero_s [NSTEPS+1];
    logic signed [ELEM_W-1:0] elem [NUM_LANES];

    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];

    // Products and numerators.
    q2r_front u_front (
        .clk     (clk),
        .en_prod (rdy[0]),
        .en_num  (rdy[1]),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .den     (den_s[0]),
        .mag     (rem_s[0]),
        .neg     (neg_s[0]),
        .zero    (zero_s[0])
    );

    // The first division step starts from an empty quotient.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_q0
        assign q_s[0][i] = '0;
    end

    // Division steps, one quotient bit per stage.
    for (genvar s = 0; s < NSTEPS; s++)
    begin : g_div
        q2r_div_stage #(
            .QW    (QW),
            .SHIFT ((s == 0) ? 1'b0 : 1'b1)
        ) u_step (
            .clk      (clk),
            .en       (rdy[s+2]),
            .den_in   (den_s[s]),
            .rem_in   (rem_s[s]),
            .q_in     (q_s[s]),
            .neg_in   (neg_s[s]),
            .zero_in  (zero_s[s]),
            .den_out  (den_s[s+1]),
            .rem_out  (rem_s[s+1]),
            .q_out    (q_s[s+1]),
            .neg_out  (neg_s[s+1]),
            .zero_out (zero_s[s+1])
        );
    end

    // Rounding, saturation and the output register.
    q2r_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk     (clk),
        .en      (rdy[NS-1]),
        .q_in    (q_s[NSTEPS]),
        .neg_in  (neg_s[NSTEPS]),
        .zero_in (zero_s[NSTEPS]),
        .elem    (elem),
        .zero    (zero_norm)
    );

    assign rot_00 = elem[0];
    assign rot_01 = elem[1];
    assign rot_02 = elem[2];
    assign rot_10 = elem[3];
    assign rot_11 = elem[4];
    assign rot_12 = elem[5];
    assign rot_20 = elem[6];
    assign rot_21 = elem[7];
    assign rot_22 = elem[8];

    // A zero quaternion must come out as a zero matrix; the diagonal, rot_01 and rot_10 are checked.
    a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> (rot_00 == '0) && (rot_11 == '0) && (rot_22 == '0)
            && (rot_01 == '0) && (rot_10 == '0))
        else $error("zero quaternion gave a nonzero matrix");

    // Input may be refused only when every stage holds an item and output stalls.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("input refused while the pipeline had room");

    // An item held at the output under a stall keeps its place in the pipeline.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> valid_reg[NS-1] && $stable(rot_00) && $stable(rot_22))
        else $error("stalled output item was lost or changed");

endmodule
